// ----- src/gsmp_pkg.sv -----
// Shared codes, constants and arithmetic helpers for the golden-section probe engine.
package gsmp_pkg;

  // Input operation codes
  localparam logic OP_START = 1'b0;
  localparam logic OP_REPLY = 1'b1;

  // Result kind codes
  localparam logic [1:0] KIND_PROBE = 2'd0;
  localparam logic [1:0] KIND_FINAL = 2'd1;
  localparam logic [1:0] KIND_ERROR = 2'd2;

  // Search stage codes
  localparam logic [1:0] STAGE_IDLE   = 2'd0;
  localparam logic [1:0] STAGE_FIRST  = 2'd1;
  localparam logic [1:0] STAGE_SECOND = 2'd2;
  localparam logic [1:0] STAGE_ITER   = 2'd3;

  // Inverse golden ratio, unsigned Q0.32, rounded to nearest
  localparam logic [31:0] INV_PHI_Q32 = 32'h9E37_79B9;

  // Signed 32-bit limits carried at 34 bits
  localparam logic signed [33:0] S34_MAX = 34'sh0_7FFF_FFFF;
  localparam logic signed [33:0] S34_MIN = 34'sh3_8000_0000;

  typedef logic signed [31:0] q_t;

  // Clamp a 34-bit signed value to the signed 32-bit range
  function automatic q_t sat32(input logic signed [33:0] v);
    q_t r;
    if (v > S34_MAX) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < S34_MIN) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  // Step = width * (1/phi), rounded half away from zero, sign of width kept
  function automatic logic signed [32:0] golden_step(input q_t w);
    logic [31:0] mag;
    logic [63:0] prod;
    logic [31:0] p;
    logic signed [32:0] s;
    mag  = w[31] ? 32'(-w) : 32'(w);
    prod = {32'd0, mag} * {32'd0, INV_PHI_Q32} + 64'h0000_0000_8000_0000;
    p    = prod[63:32];
    s    = $signed({1'b0, p});
    return w[31] ? -s : s;
  endfunction

endpackage

// ----- src/golden_section_max_probe_engine.sv -----
// Golden-section maximum search engine: start words load an interval, reply words advance it.
//
//  channel  | handshake                  | payload
//  ---------+----------------------------+----------------------------------------
//  item     | item_valid / item_ready    | op, lower_bound, upper_bound,
//           |                            | tolerance, fvalue
//  result   | result_valid / result_ready| kind, point
//
// One word per cycle while results are taken: an accepted word waits in the
// input register, then the single step datapath (one compare, one 32x32
// constant multiply, adds and clamps) writes the result register from it.
// Reset (rst, synchronous) empties both registers and returns to idle. A
// stalled result holds its register; the input register still takes one
// word, then waits until the result register drains.
module golden_section_max_probe_engine
  import gsmp_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  output logic               item_ready,
  input  logic               op,
  input  logic signed [31:0] lower_bound,
  input  logic signed [31:0] upper_bound,
  input  logic [30:0]        tolerance,
  input  logic signed [31:0] fvalue,
  output logic               result_valid,
  input  logic               result_ready,
  output logic [1:0]         kind,
  output logic signed [31:0] point
);

  // Input register
  logic        s1_valid;
  logic        s1_op;
  q_t          s1_lower;
  q_t          s1_upper;
  logic [30:0] s1_tol;
  q_t          s1_fvalue;
  logic        s1_go;

  // Search state
  logic [1:0]  stage, stage_next;
  q_t          left_end, left_end_next;
  q_t          right_end, right_end_next;
  logic [30:0] tol_held, tol_held_next;
  q_t          probe_low, probe_low_next;
  q_t          probe_high, probe_high_next;
  q_t          value_low, value_low_next;
  q_t          value_high, value_high_next;
  logic        pending_high, pending_high_next;

  // Datapath
  logic [1:0]         kind_next;
  q_t                 point_next;
  q_t                 vl_eff, vh_eff;
  logic               go_high;
  q_t                 base_a, base_b;
  q_t                 width;
  logic signed [32:0] step;
  q_t                 hi_pt, lo_pt;
  logic signed [32:0] span;
  logic               keep_going;
  logic signed [32:0] mid_sum;

  // Move the held word into the result register whenever that register frees up
  assign s1_go      = s1_valid && (!result_valid || result_ready);
  assign item_ready = !s1_valid || s1_go;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (item_ready) begin
      s1_valid <= item_valid;
    end
    if (item_valid && item_ready) begin
      s1_op     <= op;
      s1_lower  <= lower_bound;
      s1_upper  <= upper_bound;
      s1_tol    <= tolerance;
      s1_fvalue <= fvalue;
    end
  end

  // Effective objective values after this reply is stored
  always_comb begin
    vl_eff = value_low;
    vh_eff = value_high;
    unique case (stage)
      STAGE_SECOND: vh_eff = s1_fvalue;
      STAGE_ITER: begin
        if (pending_high) begin
          vh_eff = s1_fvalue;
        end else begin
          vl_eff = s1_fvalue;
        end
      end
      default: begin
        vl_eff = value_low;
      end
    endcase
  end

  // Shared step unit: width = a - b, new high probe = b + step, new low probe = a - step
  assign go_high = vl_eff < vh_eff;

  always_comb begin
    if (s1_op == OP_START) begin
      base_a = s1_upper;
      base_b = s1_lower;
    end else if (go_high) begin
      base_a = right_end;
      base_b = probe_low;
    end else begin
      base_a = probe_high;
      base_b = left_end;
    end
  end

  assign width = sat32(34'(base_a) - 34'(base_b));
  assign step  = golden_step(width);
  assign hi_pt = sat32(34'(base_b) + 34'(step));
  assign lo_pt = sat32(34'(base_a) - 34'(step));

  // Stop test and midpoint on the current interval
  assign span       = 33'(right_end) - 33'(left_end);
  assign keep_going = span > $signed({2'b00, tol_held});
  assign mid_sum    = 33'(left_end) + 33'(right_end);

  // Next state and result
  always_comb begin
    stage_next        = stage;
    left_end_next     = left_end;
    right_end_next    = right_end;
    tol_held_next     = tol_held;
    probe_low_next    = probe_low;
    probe_high_next   = probe_high;
    value_low_next    = value_low;
    value_high_next   = value_high;
    pending_high_next = pending_high;
    kind_next         = KIND_PROBE;
    point_next        = '0;
    if (s1_op == OP_START) begin
      left_end_next     = s1_lower;
      right_end_next    = s1_upper;
      tol_held_next     = s1_tol;
      probe_low_next    = lo_pt;
      probe_high_next   = hi_pt;
      value_low_next    = '0;
      value_high_next   = '0;
      pending_high_next = 1'b0;
      stage_next        = STAGE_FIRST;
      point_next        = lo_pt;
    end else begin
      unique case (stage)
        STAGE_IDLE: begin
          kind_next = KIND_ERROR;
        end
        STAGE_FIRST: begin
          value_low_next = s1_fvalue;
          stage_next     = STAGE_SECOND;
          point_next     = probe_high;
        end
        STAGE_SECOND, STAGE_ITER: begin
          value_low_next  = vl_eff;
          value_high_next = vh_eff;
          if (keep_going) begin
            stage_next = STAGE_ITER;
            if (go_high) begin
              // drop the lower end
              left_end_next     = probe_low;
              probe_low_next    = probe_high;
              value_low_next    = vh_eff;
              probe_high_next   = hi_pt;
              pending_high_next = 1'b1;
              point_next        = hi_pt;
            end else begin
              // drop the upper end
              right_end_next    = probe_high;
              probe_high_next   = probe_low;
              value_high_next   = vl_eff;
              probe_low_next    = lo_pt;
              pending_high_next = 1'b0;
              point_next        = lo_pt;
            end
          end else begin
            stage_next = STAGE_IDLE;
            kind_next  = KIND_FINAL;
            point_next = mid_sum[32:1];
          end
        end
      endcase
    end
  end

  // Search state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      stage        <= STAGE_IDLE;
      pending_high <= 1'b0;
    end else if (s1_go) begin
      stage        <= stage_next;
      pending_high <= pending_high_next;
    end
    if (s1_go) begin
      left_end   <= left_end_next;
      right_end  <= right_end_next;
      tol_held   <= tol_held_next;
      probe_low  <= probe_low_next;
      probe_high <= probe_high_next;
      value_low  <= value_low_next;
      value_high <= value_high_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (s1_go) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
    if (s1_go) begin
      kind  <= kind_next;
      point <= point_next;
    end
  end

  // A start word always leaves the engine waiting for the first probe value
  a_start_to_first: assert property (@(posedge clk) disable iff (rst)
    s1_go && s1_op == OP_START |=> stage == STAGE_FIRST)
    else $error("start word did not enter first-probe stage");

  // A final answer ends the search
  a_final_to_idle: assert property (@(posedge clk) disable iff (rst)
    s1_go && kind_next == KIND_FINAL |=> stage == STAGE_IDLE)
    else $error("final answer did not return to idle");

  // An error result carries point zero and leaves the engine idle
  a_error_result: assert property (@(posedge clk) disable iff (rst)
    s1_go && kind_next == KIND_ERROR |=> kind == KIND_ERROR && point == 32'sd0 &&
      stage == STAGE_IDLE)
    else $error("error result malformed or state changed");

endmodule
